@@ rtl/core/coefficient_bit_unpacker_defines.svh @@
// Assertion macros shared by the coefficient bit unpacker RTL.
// Each macro expects clk and arst_n to be visible at the place of use.
`ifndef COEFFICIENT_BIT_UNPACKER_DEFINES_SVH
`define COEFFICIENT_BIT_UNPACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbu: next-cycle check failed");

`endif

@@ rtl/core/cbu_pkg.sv @@
// Package of the coefficient bit unpacker: widths, register indexes and the
// state and result structures. No dependencies.
package cbu_pkg;

	localparam int unsigned COEFFS_PER_POLY = 256;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned BUF_W = 31;
	localparam int unsigned HELD_W = 5;
	localparam int unsigned WIDTH_W = 5;
	localparam int unsigned VALUE_W = 25;
	localparam int unsigned POLY_W = 4;
	localparam int unsigned CIDX_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 5;
	localparam int unsigned MAX_WIDTH = 24;
	localparam int unsigned MAX_POLYS = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF_WIDTH = 2'd0,
		REG_SIGN_EXTEND = 2'd1,
		REG_POLY_COUNT  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [BUF_W-1:0]  bits;
		logic [HELD_W-1:0] held;
		logic [CIDX_W-1:0] cidx;
		logic [POLY_W-1:0] pidx;
	} unpack_state_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [POLY_W-1:0]  pidx;
		logic [CIDX_W-1:0]  cidx;
		logic               last;
	} coeff_t;

endpackage

@@ rtl/core/cbu_step.sv @@
// One extraction step: takes the lowest coefficient out of the bit buffer,
// extends it, and advances the position counters. Depends on cbu_pkg.
module cbu_step (
	input  cbu_pkg::unpack_state_t    st,
	input  logic [cbu_pkg::WIDTH_W-1:0] width,
	input  logic [cbu_pkg::POLY_W-1:0]  last_poly,
	input  logic                        sign_ext,
	input  logic                        emit,
	output cbu_pkg::unpack_state_t    st_next,
	output cbu_pkg::coeff_t           coeff
);
	import cbu_pkg::*;

	logic [VALUE_W-1:0] wmask;
	logic [VALUE_W-1:0] raw;
	logic               last_coeff;
	logic               last_frame;

	always_comb begin
		wmask = (VALUE_W'(1) << width) - VALUE_W'(1);
		raw = st.bits[VALUE_W-1:0] & wmask;
		last_coeff = (st.cidx == CIDX_W'(COEFFS_PER_POLY - 1));
		last_frame = last_coeff && (st.pidx >= last_poly);

		coeff.value = (sign_ext && raw[width - WIDTH_W'(1)]) ? (raw | ~wmask) : raw;
		coeff.pidx = st.pidx;
		coeff.cidx = st.cidx;
		coeff.last = last_frame;
	end

	always_comb begin
		st_next = st;
		if (emit) begin
			if (last_frame) begin
				st_next = '0;
			end else begin
				st_next.bits = st.bits >> width;
				st_next.held = st.held - HELD_W'(width);
				if (last_coeff) begin
					st_next.cidx = '0;
					st_next.pidx = st.pidx + POLY_W'(1);
				end else begin
					st_next.cidx = st.cidx + CIDX_W'(1);
				end
			end
		end
	end

endmodule

@@ rtl/core/coefficient_bit_unpacker.sv @@
// Coefficient bit unpacker top level: byte input, coefficient output,
// configuration registers. Depends on cbu_pkg, cbu_step and the defines header.
//
// Bytes enter a 31-bit accumulator, LSB first; each cycle at most one
// coefficient of coeff_width bits leaves through the output register, and a
// byte is taken in the same cycle whenever the bits left after that emission
// are fewer than coeff_width. With coeff_width of 8 or more the block takes
// one byte per cycle while the output is ready; a narrower width gives up to
// eight words per byte at one word per cycle while the output is ready, the
// next byte waiting until fewer than coeff_width bits are left. The single
// extraction step in front of the output register sets this figure. in_ready
// follows out_ready combinationally. A write to a used register index, or the
// end of a frame, drops all held bits and clears both position counters.
`include "coefficient_bit_unpacker_defines.svh"

module coefficient_bit_unpacker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cbu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cbu_pkg::BYTE_W-1:0]        data_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [cbu_pkg::VALUE_W-1:0] coeff_value,
	output logic [cbu_pkg::POLY_W-1:0]        poly_index,
	output logic [cbu_pkg::CIDX_W-1:0]        coeff_index,
	output logic                              frame_last
);
	import cbu_pkg::*;

	logic [WIDTH_W-1:0]    cw_q;
	logic                  se_q;
	logic [CFG_DATA_W-1:0] pc_q;
	unpack_state_t         st_q;
	logic                  out_valid_q;
	coeff_t                out_q;

	logic [WIDTH_W-1:0]    w_eff;
	logic [CFG_DATA_W-1:0] pc_eff;
	logic [POLY_W-1:0]     last_poly;
	logic                  can_emit;
	logic                  emit;
	logic                  absorb;
	logic                  cfg_hit;
	logic                  frame_start;
	unpack_state_t         st_mid;
	unpack_state_t         st_d;
	coeff_t                coeff;

	always_comb begin
		priority if (cw_q == '0) begin
			w_eff = WIDTH_W'(1);
		end else if (cw_q > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = cw_q;
		end
		priority if (pc_q == '0) begin
			pc_eff = CFG_DATA_W'(1);
		end else if (pc_q > CFG_DATA_W'(MAX_POLYS)) begin
			pc_eff = CFG_DATA_W'(MAX_POLYS);
		end else begin
			pc_eff = pc_q;
		end
	end

	assign last_poly = POLY_W'(pc_eff - CFG_DATA_W'(1));
	assign can_emit = (st_q.held >= HELD_W'(w_eff));
	assign emit = can_emit && (!out_valid_q || out_ready);

	cbu_step u_step (
		.st        (st_q),
		.width     (w_eff),
		.last_poly (last_poly),
		.sign_ext  (se_q),
		.emit      (emit),
		.st_next   (st_mid),
		.coeff     (coeff)
	);

	assign in_ready = (st_mid.held < HELD_W'(w_eff));
	assign absorb = in_valid && in_ready;

	always_comb begin
		unique case (cfg_reg_t'(cfg_index))
			REG_COEFF_WIDTH, REG_SIGN_EXTEND, REG_POLY_COUNT: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_comb begin
		st_d = st_mid;
		if (absorb) begin
			st_d.bits = st_mid.bits | (BUF_W'(data_byte) << st_mid.held);
			st_d.held = st_mid.held + HELD_W'(BYTE_W);
		end
		if (cfg_hit) begin
			st_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= WIDTH_W'(23);
			se_q <= 1'b0;
			pc_q <= CFG_DATA_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COEFF_WIDTH: cw_q <= cfg_wdata[WIDTH_W-1:0];
				REG_SIGN_EXTEND: se_q <= cfg_wdata[0];
				REG_POLY_COUNT:  pc_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= coeff;
		end
	end

	assign out_valid = out_valid_q;
	assign coeff_value = out_q.value;
	assign poly_index = out_q.pidx;
	assign coeff_index = out_q.cidx;
	assign frame_last = out_q.last;

	assign frame_start = (st_q.cidx == '0) && (st_q.pidx == '0) &&
		(st_q.held <= HELD_W'(BYTE_W));

	// The accumulator never holds a full byte beyond one coefficient.
	`CBU_ASSERT_IMPL(a_held_bound, 1'b1, (6'(st_q.held) < (6'(w_eff) + 6'(BYTE_W))))
	// No byte is taken while a complete coefficient waits in the accumulator.
	`CBU_ASSERT_IMPL(a_no_absorb_when_full, (can_emit && !emit), !in_ready)
	// The end of a frame restarts both counters and drops the held bits.
	`CBU_ASSERT_NEXT(a_frame_restart, (emit && coeff.last), frame_start)

endmodule

@@ dv/coefficient_bit_unpacker_test.sv @@
// Self-checking test of coefficient_bit_unpacker: random byte streams under several register
// settings, each coefficient checked against a built-in unpacking predictor.
// Depends on cbu_pkg and the coefficient_bit_unpacker RTL.
`timescale 1ns / 1ps

module coefficient_bit_unpacker_test;
	import cbu_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned LONG_HOLD = 150;
	localparam int unsigned HOLD_AFTER = 100;
	localparam int unsigned WATCHDOG_NS = 5_000_000;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [BYTE_W-1:0] data_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [VALUE_W-1:0] coeff_value;
	logic [POLY_W-1:0] poly_index;
	logic [CIDX_W-1:0] coeff_index;
	logic frame_last;

	coefficient_bit_unpacker u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coeff_value(coeff_value),
		.poly_index (poly_index),
		.coeff_index(coeff_index),
		.frame_last (frame_last)
	);

	// Predictor state and its copy of the registers.
	logic [WIDTH_W-1:0] cfg_width;
	logic cfg_signed;
	logic [CFG_DATA_W-1:0] cfg_polys;
	logic [BUF_W-1:0] acc_bits;
	int unsigned acc_held;
	int unsigned pos_coeff;
	int unsigned pos_poly;

	logic [BYTE_W-1:0] pending_bytes[$];
	coeff_t coeffs_due[$];
	coeff_t due_word;

	int unsigned bytes_sent = 0;
	int unsigned bytes_taken = 0;
	int unsigned coeffs_seen = 0;
	int unsigned frame_ends = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatches = 0;
	bit quiet = 1'b0;

	logic [3:0] src_gap;
	logic [3:0] sink_gap;
	int unsigned hold_left;
	bit hold_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_frame();
		acc_bits = '0;
		acc_held = 0;
		pos_coeff = 0;
		pos_poly = 0;
	endfunction

	function automatic void unpack_byte(input logic [BYTE_W-1:0] b);
		int unsigned w;
		int unsigned cnt;
		int unsigned n;
		logic [VALUE_W-1:0] wmask;
		logic [VALUE_W-1:0] val;
		bit last_coeff;
		bit last_frame;
		coeff_t c;
		w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
		cnt = (cfg_polys == 0) ? 1 : (cfg_polys > MAX_POLYS) ? MAX_POLYS : cfg_polys;
		wmask = (25'd1 << w) - 25'd1;
		acc_bits = acc_bits | (31'(b) << acc_held);
		acc_held += 8;
		n = 0;
		while (acc_held >= w && n < 8) begin
			val = 25'(acc_bits) & wmask;
			last_coeff = (pos_coeff >= COEFFS_PER_POLY - 1);
			last_frame = last_coeff && (pos_poly >= cnt - 1);
			if (cfg_signed && val[w-1]) begin
				val = val | ~wmask;
			end
			c.value = val;
			c.pidx = pos_poly[POLY_W-1:0];
			c.cidx = pos_coeff[CIDX_W-1:0];
			c.last = last_frame;
			coeffs_due.push_back(c);
			n++;
			acc_bits = acc_bits >> w;
			acc_held -= w;
			if (last_frame) begin
				clear_frame();
				break;
			end
			if (last_coeff) begin
				pos_coeff = 0;
				pos_poly = (pos_poly + 1) & 15;
			end else begin
				pos_coeff++;
			end
		end
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			REG_COEFF_WIDTH: begin
				cfg_width = val;
				clear_frame();
			end
			REG_SIGN_EXTEND: begin
				cfg_signed = val[0];
				clear_frame();
			end
			REG_POLY_COUNT: begin
				cfg_polys = val;
				clear_frame();
			end
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		pending_bytes.push_back(b);
		bytes_sent++;
	endtask

	task automatic await_idle();
		while (bytes_taken != bytes_sent || coeffs_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] width, input logic [CFG_DATA_W-1:0] sgn,
			input logic [CFG_DATA_W-1:0] polys, input int unsigned nbytes,
			input int unsigned pause_at);
		int unsigned k;
		write_reg(REG_COEFF_WIDTH, width);
		write_reg(REG_SIGN_EXTEND, sgn);
		write_reg(REG_POLY_COUNT, polys);
		for (k = 0; k < nbytes; k++) begin
			if (pause_at != 0 && k == pause_at) begin
				await_idle();
			end
			push_byte(8'($urandom_range(0, 255)));
		end
		await_idle();
	endtask

	// Byte source: a word stays offered until taken, with random idle bursts between words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			src_gap <= '0;
		end else if (!(in_valid && !in_ready)) begin
			if (src_gap != 0) begin
				in_valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (pending_bytes.size() != 0) begin
				if (!quiet && $urandom_range(0, 5) == 0) begin
					in_valid <= 1'b0;
					src_gap <= 4'($urandom_range(0, 7));
				end else begin
					in_valid <= 1'b1;
					data_byte <= pending_bytes.pop_front();
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Coefficient sink: random stall bursts and one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_gap <= '0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && coeffs_seen >= HOLD_AFTER) begin
			out_ready <= 1'b0;
			hold_left <= LONG_HOLD - 1;
			hold_done <= 1'b1;
		end else if (sink_gap != 0) begin
			out_ready <= 1'b0;
			sink_gap <= sink_gap - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			sink_gap <= 4'($urandom_range(0, 7));
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (coeffs_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected word: value %h poly %0d index %0d last %b",
							coeff_value, poly_index, coeff_index, frame_last);
					end
				end else begin
					due_word = coeffs_due.pop_front();
					if (coeff_value !== due_word.value || poly_index !== due_word.pidx ||
							coeff_index !== due_word.cidx || frame_last !== due_word.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("word %0d: expected %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
								coeffs_seen, due_word.value, due_word.pidx, due_word.cidx,
								due_word.last, coeff_value, poly_index, coeff_index, frame_last);
						end
					end
				end
				coeffs_seen <= coeffs_seen + 1;
				frame_ends <= frame_ends + frame_last;
			end
			if (in_valid && in_ready) begin
				unpack_byte(data_byte);
				bytes_taken <= bytes_taken + 1;
			end
		end
	end

	initial begin : stimulus
		int unsigned r;
		cfg_width = 5'd23;
		cfg_signed = 1'b0;
		cfg_polys = 5'd1;
		clear_frame();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings, then one bit left held that the next register write drops.
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'h80);
		await_idle();
		write_reg(REG_SIGN_EXTEND, 5'd1);
		write_reg(REG_COEFF_WIDTH, 5'd0);
		push_byte(8'hA5);
		push_byte(8'hFF);
		await_idle();
		write_reg(REG_COEFF_WIDTH, 5'd31);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'h80);
		push_byte(8'h12);
		await_idle();
		// A write to the unused index must keep the held byte.
		write_reg(CFG_UNUSED, 5'h1F);
		push_byte(8'h34);
		push_byte(8'h56);
		await_idle();
		write_reg(REG_SIGN_EXTEND, 5'd30);
		write_reg(REG_POLY_COUNT, 5'd0);
		write_reg(REG_COEFF_WIDTH, 5'd25);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'hFF);
		await_idle();

		run_phase(5'd1, 5'd0, 5'd1, 34, 0);
		run_phase(5'd1, 5'd1, 5'd2, 68, 30);
		run_phase(5'd31, 5'd1, 5'd31, 18, 0);
		run_phase(5'd8, 5'd0, 5'd16, 14, 0);
		run_phase(5'd13, 5'd1, 5'd1, 14, 0);
		run_phase(5'd2, 5'd1, 5'd0, 16, 0);
		for (r = 0; r < 3; r++) begin
			run_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
				5'($urandom_range(0, 31)), $urandom_range(6, 10), 0);
		end
		quiet = 1'b1;
		run_phase(5'd1, 5'd0, 5'd1, 12, 0);

		$display("run: %0d bytes unpacked into %0d coefficients, %0d frame ends, %0d register writes",
			bytes_sent, coeffs_seen, frame_ends, reg_writes);
		$display("run: widths from 1 to 24, both extension modes, clamped register values, unused index");
		if (mismatches == 0 && coeffs_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("timeout with %0d coefficients outstanding", coeffs_due.size());
		$display("status: fail");
		$finish;
	end

endmodule
